/* rtl/rrt_pkg.sv */
// Package for the request retry tracker: field widths, opcode and result codes.
// Used by every module of the tracker. No dependencies.
package rrt_pkg;
	localparam int SlotsDef = 8;
	localparam int MaxTimeoutSec = 30;
	localparam int HdrBytes = 8;

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_RSP = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		K_ACCEPTED = 3'd0,
		K_INVALID = 3'd1,
		K_FULL = 3'd2,
		K_RETRANSMIT = 3'd3,
		K_MATCHED = 3'd4,
		K_NOT_FOUND = 3'd5,
		K_TIMED_OUT = 3'd6
	} kind_t;

	localparam logic [2:0] MsgRead = 3'd0;
	localparam logic [2:0] MsgReadRsp = 3'd1;
	localparam logic [2:0] MsgWriteRsp = 3'd3;

	localparam logic [1:0] CfgRetryInterval = 2'd0;
	localparam logic [1:0] CfgRetriesPerSec = 2'd1;
	localparam logic [1:0] CfgDefaultLifetime = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] seq;
		logic [2:0] msg_op;
		logic [15:0] buffer_length;
		logic [7:0] timeout_sec;
		logic has_callback;
		logic [7:0] tag;
		logic bad;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] slot;
		logic [7:0] seq_out;
		logic [7:0] tag_out;
		logic [15:0] payload_length;
		logic last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} st_t;
endpackage

/* rtl/request_retry_tracker_unit.sv */
// Timing: a send's result is registered when it is accepted. A response or tick holds the back
// while ST_SCAN visits the active slots in order, then gives its last result from ST_EMIT.
// Throughput: one send per cycle unless the output stalls.
// Reset (arst_n, asynchronous) empties the table, resets registers and the ms clock.
// Top level: front queue and back slot engine. Depends on rrt_pkg, rrt_front, rrt_back.
module request_retry_tracker_unit import rrt_pkg::*; #(
	parameter int SLOTS = SlotsDef
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode, seq, msg_op, buffer_length, timeout_sec, has_callback, tag; 48 bits.
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// kind, slot, seq_out, tag_out, payload_length; 40 bits.
	output logic [39:0] m_axis_tdata,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [9:0] cfg_data
);
	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	always_comb begin
		in_cmd.opcode = s_axis_tdata[1:0];
		in_cmd.seq = s_axis_tdata[9:2];
		in_cmd.msg_op = s_axis_tdata[12:10];
		in_cmd.buffer_length = s_axis_tdata[28:13];
		in_cmd.timeout_sec = s_axis_tdata[36:29];
		in_cmd.has_callback = s_axis_tdata[37];
		in_cmd.tag = s_axis_tdata[45:38];
		in_cmd.bad = 1'b0;
	end

	rrt_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd, .q_valid, .q_ready, .q_cmd);

	rrt_back #(.SLOTS(SLOTS)) u_back (.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.cfg_we, .cfg_index, .cfg_data, .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_res(res));

	assign m_axis_tdata = {2'b00, res.payload_length, res.tag_out, res.seq_out, res.slot,
		res.kind};
	assign m_axis_tlast = res.last;
endmodule

/* rtl/rrt_front.sv */
// Front part: accepts input transactions, checks sends, queues commands.
// Depends on rrt_pkg.
module rrt_front import rrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output cmd_t q_cmd
);
	cmd_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic push, pop;
	cmd_t c;

	always_comb begin
		c = in_cmd;
		c.bad = (in_cmd.timeout_sec > 8'(MaxTimeoutSec)) ||
			(in_cmd.buffer_length < 16'(HdrBytes));
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready && in_cmd.opcode != OP_NONE;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("ready while queue full");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("pop did not lower count");
endmodule

/* rtl/rrt_back.sv */
// Back part: slot table, ordered lists, scan sequencer and output register.
// Depends on rrt_pkg.
module rrt_back import rrt_pkg::*; #(
	parameter int SLOTS = SlotsDef
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input cmd_t q_cmd,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [9:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output res_t out_res
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [9:0] rint_q, rps_q;
	logic [4:0] dlt_q;
	logic [31:0] now_q;
	logic [7:0] seq_q [SLOTS];
	logic rd_q [SLOTS];
	logic [7:0] tag_q [SLOTS];
	logic cb_q [SLOTS];
	logic [14:0] ret_q [SLOTS];
	logic [31:0] dl_q [SLOTS];
	logic [SW-1:0] act_q [SLOTS];
	logic [SW-1:0] fre_q [SLOTS];
	logic [CW-1:0] acnt_q, fcnt_q, pos_q;
	st_t st_q, st_d;
	cmd_t cmd_q;
	logic found_q;
	res_t pend_q;
	logic ov_q;

	logic [SW-1:0] s;
	logic [31:0] diff;
	logic due, mt, at_end;
	logic [SW-1:0] fslot;
	logic [4:0] life;
	logic [14:0] budget;
	logic rel, out_free;

	assign out_free = !ov_q || out_ready;
	assign s = act_q[pos_q[SW-1:0]];
	assign diff = now_q - dl_q[s];
	assign due = !diff[31];
	assign mt = seq_q[s] == cmd_q.seq &&
		cmd_q.msg_op == (rd_q[s] ? MsgReadRsp : MsgWriteRsp);
	assign at_end = pos_q >= acnt_q;
	assign fslot = fre_q[0];
	assign life = (q_cmd.timeout_sec == 8'd0) ? dlt_q : q_cmd.timeout_sec[4:0];
	assign budget = 15'(life * rps_q);
	assign q_ready = st_q == ST_IDLE && out_free;

	// Scan step for responses and ticks; one active entry per cycle while the output is free.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (q_valid && q_ready && q_cmd.opcode != OP_SEND) st_d = ST_SCAN;
			ST_SCAN: if (out_free && (at_end || (cmd_q.opcode == OP_RSP && mt)))
				st_d = ST_EMIT;
			ST_EMIT: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rel = 1'b0;
		if (st_q == ST_SCAN && out_free && !at_end) begin
			if (cmd_q.opcode == OP_RSP) rel = mt;
			else rel = due && ret_q[s] == 15'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) cmd_q <= q_cmd;
		if (q_valid && q_ready && q_cmd.opcode == OP_SEND && !q_cmd.bad && fcnt_q != '0) begin
			seq_q[fslot] <= q_cmd.seq;
			rd_q[fslot] <= q_cmd.msg_op == MsgRead;
			tag_q[fslot] <= q_cmd.tag;
			cb_q[fslot] <= q_cmd.has_callback;
			ret_q[fslot] <= budget;
			dl_q[fslot] <= now_q + 32'(rint_q);
		end
		if (st_q == ST_SCAN && out_free && !at_end && cmd_q.opcode == OP_TICK && due &&
			ret_q[s] != 15'd0) begin
			ret_q[s] <= ret_q[s] - 15'd1;
			dl_q[s] <= now_q + 32'(rint_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rint_q <= 10'd1000;
			rps_q <= 10'd1;
			dlt_q <= 5'd5;
			now_q <= '0;
			acnt_q <= '0;
			fcnt_q <= CW'(SLOTS);
			pos_q <= '0;
			st_q <= ST_IDLE;
			found_q <= 1'b0;
			ov_q <= 1'b0;
			pend_q <= '0;
			out_res <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				act_q[i] <= '0;
				fre_q[i] <= SW'(i);
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CfgRetryInterval: rint_q <= cfg_data;
					CfgRetriesPerSec: rps_q <= cfg_data;
					CfgDefaultLifetime: dlt_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			st_q <= st_d;
			if (q_valid && q_ready) begin
				pos_q <= '0;
				found_q <= 1'b0;
				pend_q <= '0;
				if (q_cmd.opcode == OP_TICK) now_q <= now_q + 32'd1;
				if (q_cmd.opcode == OP_SEND) begin
					ov_q <= 1'b1;
					out_res.last <= 1'b1;
					out_res.seq_out <= q_cmd.seq;
					out_res.tag_out <= q_cmd.tag;
					if (q_cmd.bad) begin
						out_res.kind <= K_INVALID;
						out_res.slot <= '0;
						out_res.payload_length <= '0;
					end else if (fcnt_q == '0) begin
						out_res.kind <= K_FULL;
						out_res.slot <= '0;
						out_res.payload_length <= '0;
					end else begin
						out_res.kind <= K_ACCEPTED;
						out_res.slot <= 3'(fslot);
						out_res.payload_length <= q_cmd.buffer_length - 16'(HdrBytes);
						for (int i = 0; i < SLOTS - 1; i++) fre_q[i] <= fre_q[i+1];
						fcnt_q <= fcnt_q - 1'b1;
						act_q[acnt_q[SW-1:0]] <= fslot;
						acnt_q <= acnt_q + 1'b1;
					end
				end
			end
			if (st_q == ST_SCAN && out_free && !at_end) begin
				if (rel) begin
					for (int i = 0; i < SLOTS - 1; i++)
						if (CW'(i) >= pos_q) act_q[i] <= act_q[i+1];
					acnt_q <= acnt_q - 1'b1;
					fre_q[fcnt_q[SW-1:0]] <= s;
					fcnt_q <= fcnt_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
				// A held result goes out when a newer one replaces it, never marked last.
				if (cmd_q.opcode == OP_RSP ? mt : (due && (ret_q[s] != 15'd0 || cb_q[s]))) begin
					if (found_q) begin
						out_res <= pend_q;
						ov_q <= 1'b1;
					end
					found_q <= 1'b1;
					pend_q.kind <= cmd_q.opcode == OP_RSP ? (cb_q[s] ? K_MATCHED : K_NOT_FOUND)
						: (ret_q[s] != 15'd0 ? K_RETRANSMIT : K_TIMED_OUT);
					pend_q.slot <= 3'(s);
					pend_q.seq_out <= seq_q[s];
					pend_q.tag_out <= tag_q[s];
					pend_q.payload_length <= '0;
					pend_q.last <= 1'b0;
				end
			end
			if (st_q == ST_EMIT && out_free) begin
				if (found_q) begin
					out_res <= pend_q;
					out_res.last <= 1'b1;
					ov_q <= 1'b1;
				end else if (cmd_q.opcode == OP_RSP) begin
					out_res.kind <= K_NOT_FOUND;
					out_res.slot <= '0;
					out_res.seq_out <= cmd_q.seq;
					out_res.tag_out <= '0;
					out_res.payload_length <= '0;
					out_res.last <= 1'b1;
					ov_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = ov_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(acnt_q) + 32'(fcnt_q) == SLOTS) else $error("slot lists lost a slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> $stable(out_res)) else $error("result changed while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !q_ready) else $error("accepted during scan");
endmodule
